// ===== hdl/ctkd_pkg.sv =====
// Shared types and constants for the capacitive touch key detector.
`default_nettype none

package ctkd_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int CAL_COUNT = 10;
   localparam int CAL_AW    = 4;
   localparam int ALU_W     = 20;
   localparam int RSP_DATA_W = 40;
   localparam int DIV_PROD_W = 2 * ALU_W;
   localparam int DIV6_SHIFT = 22;

   localparam logic       CSR_CONTINUOUS_MODE = 1'b0;
   localparam logic       CSR_COUNT_LIMIT     = 1'b1;

   localparam logic       OPC_SAMPLE = 1'b0;
   localparam logic       OPC_RECAL  = 1'b1;

   localparam logic       KIND_CAL  = 1'b0;
   localparam logic       KIND_SCAN = 1'b1;

   localparam logic [15:0] COUNT_LIMIT_RESET = 16'hFFFF;
   localparam logic [3:0]  CAL_LAST          = 4'd9;
   localparam logic [3:0]  GROUP_SINGLE      = 4'd3;
   localparam logic [3:0]  GROUP_CONT        = 4'd6;
   localparam logic [2:0]  NEED_SINGLE       = 3'd2;
   localparam logic [2:0]  NEED_CONT         = 3'd4;
   localparam logic [2:0]  OVER_MAX          = 3'd7;
   localparam logic [1:0]  HOLDOFF_LOAD      = 2'd3;
   // ceil(2^22 / 6): exact floor(x / 6) for x below 2^21
   localparam logic [ALU_W-1:0] DIV6_RECIP   = 20'hAAAAB;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] res;
      logic             lt;
   } alu_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/capacitive_touch_key_detector_core.sv =====
// Top level: sequencer and datapath of the capacitive touch key detector.
`default_nettype none

// RC charge-time touch key detector. After reset or a recalibrate request
// (tuser = 1) the first ten samples build the baseline: mean of the middle
// six after sorting, found by sweeping the sample RAM for sum, two smallest
// and two largest, then a multiply by the reciprocal of six. Later samples are
// scanned in groups of three (six in continuous mode) and one scan result
// follows each group. Apart from that constant multiply, all arithmetic runs
// through one shared 20-bit adder, one operation per cycle. A scan sample runs
// over-threshold and peak compares, plus press checks when it closes a group;
// the tenth calibration sample sweeps each stored entry (read, add, min and
// max compares), then four subtracts and one multiply. Closing requests also
// wait while a previous result is still held on the rsp side.
module capacitive_touch_key_detector_core
   import ctkd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [SAMPLE_W-1:0]   req_tdata,   // [15:0] charge_time
   input  wire logic                  req_tuser,   // [0] opcode
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [0] pressed, [16:1] peak,
                                                   // [32:17] baseline, [33] cal_fail
   output logic                       rsp_tuser,   // [0] result_kind
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [15:0]           csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_OVER, S_PEAK, S_P3, S_P4, S_P10,
      C_RD, C_ADD, C_MN1, C_MN2, C_MX1, C_MX2, C_X, C_DIV, C_B5,
      S_FAIL
   } state_type;

   state_type         state_ff;
   state_type         after_fail_ff;
   logic              out_pend_ff;

   logic              cont_ff;
   logic [15:0]       count_limit_ff;
   logic              calibrating_ff;
   logic [CAL_AW-1:0] sample_idx_ff;
   logic [15:0]       group_peak_ff;
   logic [2:0]        over_cnt_ff;
   logic [15:0]       baseline_ff;
   logic [18:0]       base5_ff;
   logic [1:0]        holdoff_ff;

   logic [15:0]       sample_ff;
   logic [15:0]       peak_ff;
   logic [ALU_W-1:0]  tmp_ff;
   logic              lt1_ff;
   logic              pressed_ff;
   logic              kind_ff;

   logic [ALU_W-1:0]  sum_ff;
   logic [15:0]       min1_ff, min2_ff, max1_ff, max2_ff;
   logic [CAL_AW-1:0] ent_ff;
   logic [1:0]        xcnt_ff;
   logic [ALU_W-1:0]  div_x_ff;

   logic              rsp_tvalid_ff;
   logic              rsp_kind_ff;
   logic              rsp_pressed_ff;
   logic [15:0]       rsp_peak_ff;
   logic [15:0]       rsp_base_ff;
   logic              rsp_fail_ff;

   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;
   logic [15:0]       ram_rdata;
   logic              ram_we;
   logic              accept;
   logic              rsp_load;
   logic [DIV_PROD_W-1:0] div_prod;
   logic [15:0]       x_sel;
   logic [CAL_AW-1:0] idx_next;
   logic [3:0]        group_size;
   logic [2:0]        need;
   logic [15:0]       gp_next;
   logic [1:0]        ho_base;
   logic              detect;

   assign req_tready = (state_ff == S_IDLE) && !out_pend_ff;
   assign accept     = req_tvalid && req_tready;
   assign ram_we     = accept && (req_tuser == OPC_SAMPLE) && calibrating_ff;
   assign rsp_load   = (state_ff == S_IDLE) && out_pend_ff && (!rsp_tvalid_ff || rsp_tready);

   ctkd_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (CAL_COUNT)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (sample_idx_ff),
      .wdata (req_tdata),
      .raddr (ent_ff),
      .rdata (ram_rdata)
   );

   ctkd_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   always_comb begin
      case (xcnt_ff)
         2'd0:    x_sel = min1_ff;
         2'd1:    x_sel = min2_ff;
         2'd2:    x_sel = max1_ff;
         default: x_sel = max2_ff;
      endcase
      div_prod   = DIV_PROD_W'(div_x_ff) * DIV_PROD_W'(DIV6_RECIP);
      idx_next   = sample_idx_ff + CAL_AW'(1);
      group_size = cont_ff ? GROUP_CONT : GROUP_SINGLE;
      need       = cont_ff ? NEED_CONT : NEED_SINGLE;
      gp_next    = alu_rsp.lt ? sample_ff : group_peak_ff;
      ho_base    = cont_ff ? 2'd0 : holdoff_ff;
      detect     = lt1_ff && alu_rsp.lt;
   end

   always_comb begin
      alu_req.op = ALU_SUB;
      alu_req.a  = '0;
      alu_req.b  = '0;
      case (state_ff)
         S_OVER: begin
            alu_req.a = ALU_W'(base5_ff);
            alu_req.b = ALU_W'({sample_ff, 2'b00});
         end
         S_PEAK: begin
            alu_req.a = ALU_W'(group_peak_ff);
            alu_req.b = ALU_W'(sample_ff);
         end
         S_P3: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = ALU_W'({peak_ff, 1'b0});
            alu_req.b  = ALU_W'(peak_ff);
         end
         S_P4: begin
            alu_req.a = ALU_W'({baseline_ff, 2'b00});
            alu_req.b = tmp_ff;
         end
         S_P10: begin
            alu_req.a = ALU_W'(peak_ff);
            alu_req.b = {base5_ff, 1'b0};
         end
         S_FAIL: begin
            alu_req.a = ALU_W'(count_limit_ff[15:1]);
            alu_req.b = ALU_W'(baseline_ff);
         end
         C_ADD: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = sum_ff;
            alu_req.b  = ALU_W'(ram_rdata);
         end
         C_MN1: begin
            alu_req.a = ALU_W'(ram_rdata);
            alu_req.b = ALU_W'(min1_ff);
         end
         C_MN2: begin
            alu_req.a = ALU_W'(ram_rdata);
            alu_req.b = ALU_W'(min2_ff);
         end
         C_MX1: begin
            alu_req.a = ALU_W'(max1_ff);
            alu_req.b = ALU_W'(ram_rdata);
         end
         C_MX2: begin
            alu_req.a = ALU_W'(max2_ff);
            alu_req.b = ALU_W'(ram_rdata);
         end
         C_X: begin
            alu_req.a = sum_ff;
            alu_req.b = ALU_W'(x_sel);
         end
         C_B5: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = ALU_W'({baseline_ff, 2'b00});
            alu_req.b  = ALU_W'(baseline_ff);
         end
         default: begin
            alu_req.op = ALU_ADD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         after_fail_ff  <= S_IDLE;
         out_pend_ff    <= 1'b0;
         cont_ff        <= 1'b0;
         count_limit_ff <= COUNT_LIMIT_RESET;
         calibrating_ff <= 1'b1;
         sample_idx_ff  <= '0;
         group_peak_ff  <= '0;
         over_cnt_ff    <= '0;
         baseline_ff    <= '0;
         base5_ff       <= '0;
         holdoff_ff     <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CONTINUOUS_MODE: cont_ff        <= csr_wdata[0];
               CSR_COUNT_LIMIT:     count_limit_ff <= csr_wdata;
               default:             cont_ff        <= cont_ff;
            endcase
         end

         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (out_pend_ff) begin
                  if (rsp_load) begin
                     rsp_kind_ff    <= kind_ff;
                     rsp_pressed_ff <= pressed_ff;
                     rsp_peak_ff    <= peak_ff;
                     rsp_base_ff    <= baseline_ff;
                     rsp_fail_ff    <= lt1_ff;
                     out_pend_ff    <= 1'b0;
                  end
               end else if (accept) begin
                  sample_ff <= req_tdata;
                  if (req_tuser == OPC_RECAL) begin
                     calibrating_ff <= 1'b1;
                     sample_idx_ff  <= '0;
                     group_peak_ff  <= '0;
                     over_cnt_ff    <= '0;
                  end else if (calibrating_ff) begin
                     if (sample_idx_ff == CAL_LAST) begin
                        calibrating_ff <= 1'b0;
                        sample_idx_ff  <= '0;
                        group_peak_ff  <= '0;
                        over_cnt_ff    <= '0;
                        sum_ff         <= '0;
                        min1_ff        <= '1;
                        min2_ff        <= '1;
                        max1_ff        <= '0;
                        max2_ff        <= '0;
                        ent_ff         <= '0;
                        state_ff       <= C_RD;
                     end else begin
                        sample_idx_ff <= idx_next;
                     end
                  end else begin
                     state_ff <= S_OVER;
                  end
               end
            end
            S_OVER: begin
               if (alu_rsp.lt && (over_cnt_ff != OVER_MAX)) begin
                  over_cnt_ff <= over_cnt_ff + 3'd1;
               end
               state_ff <= S_PEAK;
            end
            S_PEAK: begin
               if (idx_next >= group_size) begin
                  peak_ff       <= (over_cnt_ff >= need) ? gp_next : '0;
                  sample_idx_ff <= '0;
                  group_peak_ff <= '0;
                  over_cnt_ff   <= '0;
                  state_ff      <= S_P3;
               end else begin
                  group_peak_ff <= gp_next;
                  sample_idx_ff <= idx_next;
                  state_ff      <= S_IDLE;
               end
            end
            S_P3: begin
               tmp_ff   <= alu_rsp.res;
               state_ff <= S_P4;
            end
            S_P4: begin
               lt1_ff   <= alu_rsp.lt;
               state_ff <= S_P10;
            end
            S_P10: begin
               pressed_ff <= detect && (ho_base == 2'd0);
               if (detect) begin
                  holdoff_ff <= HOLDOFF_LOAD - 2'd1;
               end else if (ho_base != 2'd0) begin
                  holdoff_ff <= ho_base - 2'd1;
               end else begin
                  holdoff_ff <= 2'd0;
               end
               kind_ff  <= KIND_SCAN;
               state_ff <= S_FAIL;
            end
            C_RD: begin
               state_ff <= C_ADD;
            end
            C_ADD: begin
               sum_ff   <= alu_rsp.res;
               state_ff <= C_MN1;
            end
            C_MN1: begin
               lt1_ff   <= alu_rsp.lt;
               state_ff <= C_MN2;
            end
            C_MN2: begin
               if (lt1_ff) begin
                  min2_ff <= min1_ff;
                  min1_ff <= ram_rdata;
               end else if (alu_rsp.lt) begin
                  min2_ff <= ram_rdata;
               end
               state_ff <= C_MX1;
            end
            C_MX1: begin
               lt1_ff   <= alu_rsp.lt;
               state_ff <= C_MX2;
            end
            C_MX2: begin
               if (lt1_ff) begin
                  max2_ff <= max1_ff;
                  max1_ff <= ram_rdata;
               end else if (alu_rsp.lt) begin
                  max2_ff <= ram_rdata;
               end
               if (ent_ff == CAL_LAST) begin
                  xcnt_ff  <= '0;
                  state_ff <= C_X;
               end else begin
                  ent_ff   <= ent_ff + CAL_AW'(1);
                  state_ff <= C_RD;
               end
            end
            C_X: begin
               xcnt_ff <= xcnt_ff + 2'd1;
               if (xcnt_ff == 2'd3) begin
                  div_x_ff <= alu_rsp.res;
                  state_ff <= C_DIV;
               end else begin
                  sum_ff <= alu_rsp.res;
               end
            end
            C_DIV: begin
               baseline_ff <= div_prod[DIV6_SHIFT +: SAMPLE_W];
               state_ff    <= C_B5;
            end
            C_B5: begin
               base5_ff   <= alu_rsp.res[18:0];
               kind_ff    <= KIND_CAL;
               pressed_ff <= 1'b0;
               peak_ff    <= '0;
               state_ff   <= S_FAIL;
            end
            S_FAIL: begin
               lt1_ff      <= alu_rsp.lt;
               out_pend_ff <= 1'b1;
               state_ff    <= after_fail_ff;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_fail_ff, rsp_base_ff, rsp_peak_ff, rsp_pressed_ff});

   // request is held off while a finished result waits for the output register
   assert property (@(posedge clock) disable iff (reset)
      out_pend_ff |-> !req_tready)
      else $error("request accepted with a result pending");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ({1'b0, over_cnt_ff} <= sample_idx_ff))
      else $error("over count exceeds samples in group");

   assert property (@(posedge clock) disable iff (reset)
      holdoff_ff != HOLDOFF_LOAD)
      else $error("holdoff left at load value");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_CAL)) |-> (rsp_tdata[16:0] == 17'd0))
      else $error("calibration result carries press or peak");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[16:1] != 16'd0))
      else $error("press reported with zero peak");

endmodule

`default_nettype wire

// ===== hdl/ctkd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ctkd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 10
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/ctkd_alu.sv =====
// Shared adder/subtractor with less-than flag from the subtract borrow.
`default_nettype none

module ctkd_alu
   import ctkd_pkg::*;
(
   input  wire alu_req_type alu_req,
   output alu_rsp_type      alu_rsp
);

   logic [ALU_W-1:0] b_op;
   logic             is_sub;
   logic [ALU_W:0]   full;

   always_comb begin
      is_sub = (alu_req.op == ALU_SUB);
      b_op   = is_sub ? ~alu_req.b : alu_req.b;
      full   = {1'b0, alu_req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, is_sub};
      alu_rsp.res = full[ALU_W-1:0];
      alu_rsp.lt  = is_sub & ~full[ALU_W];
   end

endmodule

`default_nettype wire

// ===== verif/capacitive_touch_key_detector_core_tb.sv =====
// Self-checking testbench: directed table then random touch sessions, scored against a predictor.
module capacitive_touch_key_detector_core_tb;
   import ctkd_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int SETTLE_CYCLES  = 120;
   localparam int LONG_STALL     = 400;
   localparam int PHASES         = 10;
   localparam int PHASE_REQUESTS = 170;
   localparam int DIR_ROWS       = 22;

   typedef struct packed {
      logic        kind;
      logic        pressed;
      logic [15:0] peak;
      logic [15:0] baseline;
      logic        cal_fail;
   } touch_result_t;

   typedef struct packed {
      logic          op;
      logic [15:0]   data;
      logic          typed;
      touch_result_t res;
   } dir_row_t;

   localparam touch_result_t NO_RESULT = '0;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we;
   logic                  csr_index;
   logic [15:0]           csr_wdata;

   capacitive_touch_key_detector_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predictor state
   logic [15:0] cal_mem [CAL_COUNT];
   bit          in_cal;
   logic [3:0]  samp_idx;
   logic [15:0] grp_max;
   logic [2:0]  over_cnt;
   logic [15:0] base_val;
   logic [1:0]  hold_cnt;
   logic        mode_cont;
   logic [15:0] limit_val;

   touch_result_t expected_q [$];
   dir_row_t      dir_rows [DIR_ROWS];

   bit sender_idling;
   bit receiver_idling;
   bit hold_asked;
   bit hold_seen;
   bit finger_down;
   int pad_level;

   int error_count;
   int cycle_count;
   int n_requests;
   int n_results;
   int n_presses;
   int n_cals;
   int n_cal_fails;

   function automatic logic [15:0] clamp16(input int v);
      if (v < 0)
         return 16'h0000;
      if (v > 65535)
         return 16'hFFFF;
      return v[15:0];
   endfunction

   function automatic touch_result_t tres(input logic kind, input logic pressed,
                                          input logic [15:0] peak,
                                          input logic [15:0] baseline, input logic fail);
      touch_result_t r;
      r.kind     = kind;
      r.pressed  = pressed;
      r.peak     = peak;
      r.baseline = baseline;
      r.cal_fail = fail;
      return r;
   endfunction

   function automatic dir_row_t drow(input logic op, input logic [15:0] d, input logic typed,
                                     input touch_result_t res);
      dir_row_t row;
      row.op    = op;
      row.data  = d;
      row.typed = typed;
      row.res   = res;
      return row;
   endfunction

   task automatic predict_touch(input logic op, input logic [15:0] smp, output bit has,
                                output touch_result_t r);
      logic [15:0] srt [CAL_COUNT];
      logic [15:0] t;
      logic [15:0] pk;
      logic [3:0]  size_now;
      logic [2:0]  need_now;
      int unsigned b;
      int unsigned total;
      int i;
      int j;
      b   = base_val;
      has = 0;
      r   = NO_RESULT;
      if (op == OPC_RECAL) begin
         in_cal   = 1;
         samp_idx = 0;
         grp_max  = 0;
         over_cnt = 0;
      end else if (in_cal) begin
         cal_mem[samp_idx] = smp;
         samp_idx = samp_idx + 4'd1;
         if (samp_idx == CAL_COUNT) begin
            for (i = 0; i < CAL_COUNT; i++)
               srt[i] = cal_mem[i];
            for (i = 0; i < CAL_COUNT - 1; i++)
               for (j = i + 1; j < CAL_COUNT; j++)
                  if (srt[i] > srt[j]) begin
                     t      = srt[i];
                     srt[i] = srt[j];
                     srt[j] = t;
                  end
            total = 0;
            for (i = 2; i < 8; i++)
               total += srt[i];
            base_val = 16'(total / 6);
            in_cal   = 0;
            samp_idx = 0;
            grp_max  = 0;
            over_cnt = 0;
            has = 1;
            r = tres(KIND_CAL, 1'b0, 16'd0, base_val, base_val > (limit_val >> 1));
         end
      end else begin
         if (smp > b * 5 / 4 && over_cnt < OVER_MAX)
            over_cnt = over_cnt + 3'd1;
         if (smp > grp_max)
            grp_max = smp;
         samp_idx = samp_idx + 4'd1;
         size_now = mode_cont ? GROUP_CONT : GROUP_SINGLE;
         need_now = mode_cont ? NEED_CONT : NEED_SINGLE;
         if (samp_idx >= size_now) begin
            pk = (over_cnt >= need_now) ? grp_max : 16'd0;
            r = tres(KIND_SCAN, 1'b0, pk, base_val, base_val > (limit_val >> 1));
            if (mode_cont)
               hold_cnt = 0;
            if (pk > b * 4 / 3 && pk < b * 10) begin
               if (hold_cnt == 0)
                  r.pressed = 1'b1;
               hold_cnt = HOLDOFF_LOAD;
            end
            if (hold_cnt != 0)
               hold_cnt = hold_cnt - 2'd1;
            samp_idx = 0;
            grp_max  = 0;
            over_cnt = 0;
            has = 1;
         end
      end
   endtask

   // pad model: calibrate around a pad level, then untouched / touched groups
   task automatic gen_request(output logic op, output logic [15:0] d);
      int b;
      int r;
      int v;
      b  = base_val;
      r  = $urandom_range(0, 99);
      op = OPC_SAMPLE;
      if ($urandom_range(0, 99) < 2) begin
         op = OPC_RECAL;
         d  = 16'($urandom_range(0, 65535));
      end else if (in_cal) begin
         if (samp_idx == 0) begin
            v = $urandom_range(0, 99);
            if (v < 5)
               pad_level = 0;
            else if (v < 8)
               pad_level = 65535;
            else if (v < 40)
               pad_level = $urandom_range(0, 200);
            else if (v < 90)
               pad_level = $urandom_range(200, 6000);
            else
               pad_level = $urandom_range(6000, 65535);
         end
         if (r < 10)
            d = 16'($urandom_range(0, 65535));
         else
            d = clamp16(pad_level - pad_level / 16 - 3
                        + int'($urandom_range(0, 2 * (pad_level / 16 + 3))));
      end else begin
         if (samp_idx == 0)
            finger_down = ($urandom_range(0, 99) < 40);
         if (r < 4) begin
            case ($urandom_range(0, 7))
               0:       v = b * 5 / 4;
               1:       v = b * 5 / 4 + 1;
               2:       v = b * 4 / 3;
               3:       v = b * 4 / 3 + 1;
               4:       v = b * 10;
               5:       v = b * 10 - 1;
               6:       v = 0;
               default: v = 65535;
            endcase
            d = clamp16(v);
         end else if (r < 12) begin
            d = 16'($urandom_range(0, 65535));
         end else if (finger_down && $urandom_range(0, 99) < 85) begin
            d = clamp16(b + b * int'($urandom_range(25, 300)) / 100
                        + int'($urandom_range(0, 3)));
         end else begin
            d = clamp16(b - b / 8 - 2 + int'($urandom_range(0, 2 * (b / 8 + 2))));
         end
      end
   endtask

   task automatic send_request(input logic op, input logic [15:0] d, input logic typed,
                               input touch_result_t typed_res);
      bit            has;
      touch_result_t r;
      @(negedge clock);
      while (sender_idling && $urandom_range(0, 99) < 19) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
      predict_touch(op, d, has, r);
      if (typed) begin
         has = 1;
         r   = typed_res;
      end
      if (has)
         expected_q.push_back(r);
      n_requests++;
   endtask

   task automatic send_random();
      logic        op;
      logic [15:0] d;
      gen_request(op, d);
      send_request(op, d, 1'b0, NO_RESULT);
   endtask

   task automatic csr_write(input logic idx, input logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CONTINUOUS_MODE)
         mode_cont = val[0];
      else
         limit_val = val;
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         error_count++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("capacitive_touch_key_detector_core_tb: errors");
         $finish;
      end
   end

   // response side: random backpressure plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(negedge clock);
         end else begin
            rsp_tready <= !(receiver_idling && $urandom_range(0, 99) < 19);
         end
      end
   end

   always @(posedge clock) begin : score
      touch_result_t want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         n_results++;
         if (expected_q.size() == 0) begin
            $error("response with nothing pending: tuser %0b tdata %h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            check_field("result_kind", want.kind, rsp_tuser);
            check_field("pressed", want.pressed, rsp_tdata[0]);
            check_field("peak", want.peak, rsp_tdata[16:1]);
            check_field("baseline", want.baseline, rsp_tdata[32:17]);
            check_field("cal_fail", want.cal_fail, rsp_tdata[33]);
            check_field("tdata pad", 16'd0, rsp_tdata[RSP_DATA_W-1:34]);
            if (want.kind == KIND_CAL) begin
               n_cals++;
               if (want.cal_fail)
                  n_cal_fails++;
            end else if (want.pressed) begin
               n_presses++;
            end
         end
      end
   end

   initial begin : driver
      logic        mode_w;
      logic [15:0] limit_w;
      int          ph;
      int          k;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = OPC_SAMPLE;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_CONTINUOUS_MODE;
      csr_wdata  = '0;
      sender_idling   = 1;
      receiver_idling = 1;
      in_cal    = 1;
      samp_idx  = 0;
      grp_max   = 0;
      over_cnt  = 0;
      base_val  = 0;
      hold_cnt  = 0;
      mode_cont = 1'b0;
      limit_val = COUNT_LIMIT_RESET;

      // reset config: single mode, count limit 65535
      dir_rows[0]  = drow(OPC_RECAL,  16'hFFFF, 1'b0, NO_RESULT);
      dir_rows[1]  = drow(OPC_SAMPLE, 16'h0000, 1'b0, NO_RESULT);
      dir_rows[2]  = drow(OPC_SAMPLE, 16'h0000, 1'b0, NO_RESULT);
      dir_rows[3]  = drow(OPC_SAMPLE, 16'h0000, 1'b0, NO_RESULT);
      dir_rows[4]  = drow(OPC_SAMPLE, 16'h0000, 1'b0, NO_RESULT);
      dir_rows[5]  = drow(OPC_SAMPLE, 16'h0000, 1'b0, NO_RESULT);
      dir_rows[6]  = drow(OPC_SAMPLE, 16'hFFFF, 1'b0, NO_RESULT);
      dir_rows[7]  = drow(OPC_SAMPLE, 16'hFFFF, 1'b0, NO_RESULT);
      dir_rows[8]  = drow(OPC_SAMPLE, 16'hFFFF, 1'b0, NO_RESULT);
      dir_rows[9]  = drow(OPC_SAMPLE, 16'hFFFF, 1'b0, NO_RESULT);
      // baseline right at count_limit/2: no failure
      dir_rows[10] = drow(OPC_SAMPLE, 16'hFFFF, 1'b1,
                          tres(KIND_CAL, 1'b0, 16'd0, 16'd32767, 1'b0));
      dir_rows[11] = drow(OPC_SAMPLE, 16'hFFFF, 1'b0, NO_RESULT);
      dir_rows[12] = drow(OPC_SAMPLE, 16'hFFFF, 1'b0, NO_RESULT);
      dir_rows[13] = drow(OPC_SAMPLE, 16'h0000, 1'b1,
                          tres(KIND_SCAN, 1'b1, 16'hFFFF, 16'd32767, 1'b0));
      // repeat detection blocked by holdoff
      dir_rows[14] = drow(OPC_SAMPLE, 16'hFFFF, 1'b0, NO_RESULT);
      dir_rows[15] = drow(OPC_SAMPLE, 16'hFFFF, 1'b0, NO_RESULT);
      dir_rows[16] = drow(OPC_SAMPLE, 16'hFFFF, 1'b1,
                          tres(KIND_SCAN, 1'b0, 16'hFFFF, 16'd32767, 1'b0));
      // one sample over threshold: too few, peak 0
      dir_rows[17] = drow(OPC_SAMPLE, 16'h0000, 1'b0, NO_RESULT);
      dir_rows[18] = drow(OPC_SAMPLE, 16'h0000, 1'b0, NO_RESULT);
      dir_rows[19] = drow(OPC_SAMPLE, 16'd40959, 1'b1,
                          tres(KIND_SCAN, 1'b0, 16'd0, 16'd32767, 1'b0));
      // recalibrate with a partial group pending
      dir_rows[20] = drow(OPC_SAMPLE, 16'hFFFF, 1'b0, NO_RESULT);
      dir_rows[21] = drow(OPC_RECAL,  16'h1234, 1'b0, NO_RESULT);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIR_ROWS; k++)
         send_request(dir_rows[k].op, dir_rows[k].data, dir_rows[k].typed, dir_rows[k].res);
      wait_quiet();

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin mode_w = 1'b1; limit_w = 16'hFFFF; end
            1: begin mode_w = 1'b0; limit_w = 16'h0000; end
            2: begin mode_w = 1'b1; limit_w = 16'h0000; end
            3: begin mode_w = 1'b0; limit_w = 16'h0001; end
            4: begin mode_w = 1'b1; limit_w = 16'hFFFF; end
            5: begin mode_w = 1'b0; limit_w = 16'($urandom_range(0, 65535)); end
            default: begin
               mode_w  = 1'($urandom_range(0, 1));
               limit_w = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
            end
         endcase
         csr_write(CSR_CONTINUOUS_MODE, 16'(($urandom_range(0, 32767) << 1) | mode_w));
         csr_write(CSR_COUNT_LIMIT, limit_w);
         sender_idling   = (ph != 4);
         receiver_idling = (ph != 4);
         for (k = 0; k < PHASE_REQUESTS; k++) begin
            if (ph == 5 && k == 20)
               hold_asked = !hold_asked;
            send_random();
         end
         // leave a six-group part filled so the next mode switch cuts it short
         if (mode_cont)
            while (in_cal || samp_idx != 4)
               send_random();
         wait_quiet();
      end

      $display("ran %0d requests, %0d responses: %0d calibrations (%0d failed), %0d presses",
               n_requests, n_results, n_cals, n_cal_fails, n_presses);
      $display("both group sizes, mid-group mode switch, count limits 0..65535, long rsp stall");
      if (error_count == 0)
         $display("capacitive_touch_key_detector_core_tb: clean");
      else
         $display("capacitive_touch_key_detector_core_tb: errors");
      $finish;
   end

endmodule
